// File: hdl/cmrb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmrb_pkg
// shared constants, beat types and helpers of the coalescing message ring
// ----------------------------------------------------------------------------
package cmrb_pkg;

	localparam int SLOTS       = 4;
	localparam int BLOCK_BYTES = 64;

	localparam int DEPTH  = SLOTS * BLOCK_BYTES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int FILL_W = $clog2(BLOCK_BYTES + 1);
	localparam int CNT_W  = 7;

	// request kinds
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_ENDED     = 3'd1;
	localparam logic [2:0] ST_NO_DATA   = 3'd2;
	localparam logic [2:0] ST_TOO_SMALL = 3'd3;
	localparam logic [2:0] ST_REJECTED  = 3'd4;

	typedef struct packed {
		logic             req_type;
		logic [CNT_W-1:0] chunk_size;
		logic             first_beat;
		logic             last_beat;
		logic [7:0]       data_byte;
		logic             end_mark;
		logic [CNT_W-1:0] read_capacity;
	} req_beat_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last_result;
	} rsp_beat_t;

	// result handed from the controller to the output register
	typedef struct packed {
		logic       load;
		logic [2:0] status;
		logic       byte_valid;
		logic       last_result;
	} res_t;

	// one write into the slot table
	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] slot;
		logic [FILL_W-1:0] fill;
		logic              ended;
	} meta_wr_t;

	// one write into the byte memory
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

	function automatic logic [ADDR_W-1:0] base_addr(input logic [SLOT_W-1:0] s);
		return ADDR_W'(s) * ADDR_W'(BLOCK_BYTES);
	endfunction

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
	endfunction

endpackage
`default_nettype wire

// File: hdl/cmrb_byte_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmrb_byte_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module cmrb_byte_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/cmrb_slot_meta.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmrb_slot_meta
// per-slot fill count and end mark, one read slot and one write per cycle
// ----------------------------------------------------------------------------
module cmrb_slot_meta (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [cmrb_pkg::SLOT_W-1:0] rd_slot,
	output logic      [cmrb_pkg::FILL_W-1:0] rd_fill,
	output logic                           rd_ended,
	input  wire cmrb_pkg::meta_wr_t        wr
);

	logic [cmrb_pkg::FILL_W-1:0] fill_q  [cmrb_pkg::SLOTS];
	logic                        ended_q [cmrb_pkg::SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cmrb_pkg::SLOTS; i++) begin
				fill_q[i]  <= '0;
				ended_q[i] <= 1'b0;
			end
		end else if (wr.we) begin
			fill_q[wr.slot]  <= wr.fill;
			ended_q[wr.slot] <= wr.ended;
		end
	end

	assign rd_fill  = fill_q[rd_slot];
	assign rd_ended = ended_q[rd_slot];

endmodule
`default_nettype wire

// File: hdl/cmrb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmrb_ctrl
// ring pointers, chunk tracking and the read streaming sequencer
// ----------------------------------------------------------------------------
module cmrb_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	input  wire cmrb_pkg::req_beat_t         req,
	output logic                             req_ready,
	input  wire logic                        out_free,
	output logic      [cmrb_pkg::SLOT_W-1:0] meta_rd_slot,
	input  wire logic [cmrb_pkg::FILL_W-1:0] meta_fill,
	input  wire logic                        meta_ended,
	output cmrb_pkg::meta_wr_t               meta_wr,
	output cmrb_pkg::ram_wr_t                ram_wr,
	output logic                             ram_re,
	output logic      [cmrb_pkg::ADDR_W-1:0] ram_raddr,
	output cmrb_pkg::res_t                   res
);

	localparam int SW = cmrb_pkg::SLOT_W;
	localparam int FW = cmrb_pkg::FILL_W;
	localparam int CW = cmrb_pkg::CNT_W;

	logic [SW-1:0] head_q, tail_q, open_slot_q;
	logic          open_valid_q, chunk_act_q, chunk_rej_q;
	logic [FW-1:0] left_q;
	logic          str_q;
	logic [FW-1:0] str_idx_q, str_cnt_q;
	logic [2:0]    str_st_q;
	logic [SW-1:0] str_slot_q;

	logic [SW-1:0] head_n, tail_n, open_slot_n;
	logic          open_valid_n, chunk_act_n, chunk_rej_n;
	logic [FW-1:0] left_n;
	logic          str_n;
	logic [FW-1:0] str_idx_n;
	logic          str_load;

	logic          acc;
	logic          new_slot, store, store_wr, set_end, full, str_last;
	logic [SW-1:0] eff_open;
	logic [FW-1:0] eff_fill, eff_left;
	logic          eff_valid, eff_rej, eff_act;
	logic [SW:0]   used;

	assign req_ready    = !str_q && out_free;
	assign acc          = req_valid && req_ready;
	assign meta_rd_slot = (req.req_type == cmrb_pkg::REQ_READ) ? head_q : open_slot_q;
	assign str_last     = (str_idx_q + FW'(1)) == str_cnt_q;

	always_comb begin
		used = (tail_q >= head_q) ? ({1'b0, tail_q} - {1'b0, head_q})
			: ({1'b0, tail_q} + (SW+1)'(cmrb_pkg::SLOTS) - {1'b0, head_q});
		full = used >= (SW+1)'(cmrb_pkg::SLOTS - 1);
	end

	always_comb begin
		head_n       = head_q;
		tail_n       = tail_q;
		open_slot_n  = open_slot_q;
		open_valid_n = open_valid_q;
		chunk_act_n  = chunk_act_q;
		chunk_rej_n  = chunk_rej_q;
		left_n       = left_q;
		str_n        = str_q;
		str_idx_n    = str_idx_q;
		str_load     = 1'b0;
		meta_wr      = '0;
		ram_wr       = '0;
		ram_re       = 1'b0;
		ram_raddr    = '0;
		res          = '0;
		new_slot     = 1'b0;
		store        = 1'b0;
		store_wr     = 1'b0;
		set_end      = 1'b0;
		eff_act      = chunk_act_q;
		eff_rej      = chunk_rej_q;
		eff_left     = left_q;
		eff_valid    = open_valid_q;
		eff_open     = open_slot_q;
		eff_fill     = meta_fill;

		if (acc && req.req_type == cmrb_pkg::REQ_WRITE) begin
			// chunk start: append to open slot, open a new tail slot, or reject the chunk
			if (req.first_beat) begin
				eff_act  = 1'b1;
				eff_rej  = 1'b0;
				eff_left = '0;
				if (req.chunk_size > CW'(cmrb_pkg::BLOCK_BYTES)) begin
					eff_rej = 1'b1;
				end else if (open_valid_q && !meta_ended &&
						(CW'(cmrb_pkg::BLOCK_BYTES) - CW'(meta_fill)) >= req.chunk_size) begin
					eff_left = FW'(req.chunk_size);
				end else if (full) begin
					eff_rej = 1'b1;
				end else begin
					new_slot  = 1'b1;
					eff_open  = tail_q;
					eff_valid = 1'b1;
					eff_fill  = '0;
					tail_n    = cmrb_pkg::next_slot(tail_q);
					eff_left  = FW'(req.chunk_size);
				end
			end

			store = eff_act && !eff_rej && eff_valid && (eff_left != '0);
			if (store) begin
				if (CW'(eff_fill) < CW'(cmrb_pkg::BLOCK_BYTES)) begin
					store_wr     = 1'b1;
					ram_wr.we    = 1'b1;
					ram_wr.addr  = cmrb_pkg::base_addr(eff_open) +
						cmrb_pkg::ADDR_W'(eff_fill);
					ram_wr.data  = req.data_byte;
				end
				eff_left = eff_left - FW'(1);
			end
			set_end = req.last_beat && eff_act && !eff_rej && eff_valid && req.end_mark;

			meta_wr.we    = eff_act && (new_slot || store_wr || set_end);
			meta_wr.slot  = eff_open;
			meta_wr.fill  = store_wr ? eff_fill + FW'(1) : eff_fill;
			meta_wr.ended = (new_slot ? 1'b0 : meta_ended) | set_end;

			if (req.last_beat) begin
				res.load        = 1'b1;
				res.status      = (!eff_act || eff_rej) ? cmrb_pkg::ST_REJECTED
					: cmrb_pkg::ST_OK;
				res.last_result = 1'b1;
			end

			chunk_act_n  = req.last_beat ? 1'b0 : eff_act;
			chunk_rej_n  = eff_rej;
			left_n       = req.last_beat ? '0 : eff_left;
			open_valid_n = eff_valid;
			open_slot_n  = eff_open;
		end

		if (acc && req.req_type == cmrb_pkg::REQ_READ) begin
			res.load        = 1'b1;
			res.last_result = 1'b1;
			if (head_q == tail_q) begin
				res.status = cmrb_pkg::ST_NO_DATA;
			end else if (CW'(meta_fill) > req.read_capacity) begin
				res.status = cmrb_pkg::ST_TOO_SMALL;
			end else begin
				// pop the head slot; bytes follow from the sequencer
				res.status    = meta_ended ? cmrb_pkg::ST_ENDED : cmrb_pkg::ST_OK;
				meta_wr.we    = 1'b1;
				meta_wr.slot  = head_q;
				meta_wr.fill  = '0;
				meta_wr.ended = 1'b0;
				head_n        = cmrb_pkg::next_slot(head_q);
				if (open_valid_q && open_slot_q == head_q) begin
					open_valid_n = 1'b0;
					if (chunk_act_q) begin
						chunk_rej_n = 1'b1;
						left_n      = '0;
					end
				end
				if (meta_fill != '0) begin
					res.load  = 1'b0;
					str_n     = 1'b1;
					str_idx_n = '0;
					str_load  = 1'b1;
				end
			end
		end

		if (str_q && out_free) begin
			ram_re          = 1'b1;
			ram_raddr       = cmrb_pkg::base_addr(str_slot_q) + cmrb_pkg::ADDR_W'(str_idx_q);
			res.load        = 1'b1;
			res.status      = str_st_q;
			res.byte_valid  = 1'b1;
			res.last_result = str_last;
			str_idx_n       = str_idx_q + FW'(1);
			str_n           = !str_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			open_slot_q  <= '0;
			open_valid_q <= 1'b0;
			chunk_act_q  <= 1'b0;
			chunk_rej_q  <= 1'b0;
			left_q       <= '0;
			str_q        <= 1'b0;
			str_idx_q    <= '0;
		end else begin
			head_q       <= head_n;
			tail_q       <= tail_n;
			open_slot_q  <= open_slot_n;
			open_valid_q <= open_valid_n;
			chunk_act_q  <= chunk_act_n;
			chunk_rej_q  <= chunk_rej_n;
			left_q       <= left_n;
			str_q        <= str_n;
			str_idx_q    <= str_idx_n;
		end
	end

	// message being streamed
	always_ff @(posedge clk) begin
		if (str_load) begin
			str_cnt_q  <= meta_fill;
			str_st_q   <= meta_ended ? cmrb_pkg::ST_ENDED : cmrb_pkg::ST_OK;
			str_slot_q <= head_q;
		end
	end

endmodule
`default_nettype wire

// File: hdl/coalescing_message_ring_buffer.sv
// write beat: its result sits in the output register in the cycle after the beat is taken;
// one write beat per cycle while the output register drains
// read: status-only answers follow in the cycle after acceptance; a popped message streams from
// the byte memory via the stream flag register, then the read data and output registers, one
// byte per cycle while the output register drains; no request is taken meanwhile
// reset: pointers, fill counts and end marks clear at once; the byte memory is not cleared
`default_nettype none
// ----------------------------------------------------------------------------
// coalescing_message_ring_buffer
// ring of message slots with chunk coalescing on write and whole-message pop
// ----------------------------------------------------------------------------
module coalescing_message_ring_buffer (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire cmrb_pkg::req_beat_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output cmrb_pkg::rsp_beat_t      rsp
);

	// slot table port
	logic [cmrb_pkg::SLOT_W-1:0] meta_rd_slot;
	logic [cmrb_pkg::FILL_W-1:0] meta_fill;
	logic                        meta_ended;
	cmrb_pkg::meta_wr_t          meta_wr;

	// byte memory ports
	cmrb_pkg::ram_wr_t           ram_wr;
	logic                        ram_re;
	logic [cmrb_pkg::ADDR_W-1:0] ram_raddr;
	logic [7:0]                  ram_rdata;

	// output stage
	cmrb_pkg::res_t res;
	logic           out_free;
	logic           rsp_valid_q;
	logic [2:0]     status_q;
	logic           byte_valid_q;
	logic           last_q;

	// output register is free when empty or being taken this cycle
	assign out_free = !rsp_valid_q || rsp_ready;

	cmrb_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req          (req),
		.req_ready    (req_ready),
		.out_free     (out_free),
		.meta_rd_slot (meta_rd_slot),
		.meta_fill    (meta_fill),
		.meta_ended   (meta_ended),
		.meta_wr      (meta_wr),
		.ram_wr       (ram_wr),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.res          (res)
	);

	cmrb_slot_meta u_meta (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_slot  (meta_rd_slot),
		.rd_fill  (meta_fill),
		.rd_ended (meta_ended),
		.wr       (meta_wr)
	);

	// read data register doubles as the byte field of the output beat:
	// it only advances when a byte beat is loaded into the output stage
	cmrb_byte_ram #(
		.DEPTH (cmrb_pkg::DEPTH),
		.WIDTH (8)
	) u_ram (
		.clk   (clk),
		.we    (ram_wr.we),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= res.load;
		end
	end

	// beat fields, no reset needed
	always_ff @(posedge clk) begin
		if (out_free && res.load) begin
			status_q     <= res.status;
			byte_valid_q <= res.byte_valid;
			last_q       <= res.last_result;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.out_byte    = byte_valid_q ? ram_rdata : 8'h00;
	assign rsp.byte_valid  = byte_valid_q;
	assign rsp.last_result = last_q;

endmodule
`default_nettype wire

// File: hdl/cmrb_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmrb_checker
// port-level checks of the message ring, bound to the top level
// ----------------------------------------------------------------------------
module cmrb_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_ready,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire cmrb_pkg::rsp_beat_t rsp
);

	// stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	// status-only beats close their request
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.byte_valid |-> rsp.last_result)
		else $error("status-only beat without last mark");

	// status-only beats carry a zero byte
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.byte_valid |-> rsp.out_byte == 8'h00)
		else $error("status-only beat with nonzero byte");

	// message bytes only come with ok or ended status
	a_byte_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.byte_valid |->
			rsp.status == cmrb_pkg::ST_OK || rsp.status == cmrb_pkg::ST_ENDED)
		else $error("message byte with bad status");

	// no request taken in the middle of a popped message
	a_stream_block: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last_result |-> !req_ready)
		else $error("request taken while a message streams");

endmodule

bind coalescing_message_ring_buffer cmrb_checker u_cmrb_checker (.*);
`default_nettype wire

// File: bench/ring_mirror_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_mirror_pkg
// untimed mirror of the message ring: replays accepted beats against its own
// slot table and checks each reply beat against the oldest one owed
// ----------------------------------------------------------------------------
package ring_mirror_pkg;

	import cmrb_pkg::*;

	class ring_mirror;

		logic [7:0]  slot_data [SLOTS*BLOCK_BYTES];
		int unsigned fill [SLOTS];
		bit          ended [SLOTS];
		int unsigned head;
		int unsigned tail;
		int unsigned open_idx;
		bit          open_ok;
		bit          dropped;
		bit          in_chunk;
		int unsigned left;

		rsp_beat_t   owed [$];
		int unsigned faults;

		function void owe(logic [2:0] st, logic [7:0] b, logic v, logic l);
			owed.push_back('{status: st, out_byte: b, byte_valid: v, last_result: l});
		endfunction

		// read request: pop the head slot or report why not
		function void pop_head(int unsigned cap);
			int unsigned h;
			int unsigned n;
			logic [2:0]  st;
			h = head;
			if (head == tail) begin
				owe(ST_NO_DATA, 8'h00, 1'b0, 1'b1);
				return;
			end
			n = fill[h];
			if (n > cap) begin
				owe(ST_TOO_SMALL, 8'h00, 1'b0, 1'b1);
				return;
			end
			st = ended[h] ? ST_ENDED : ST_OK;
			if (n == 0)
				owe(st, 8'h00, 1'b0, 1'b1);
			else
				for (int k = 0; k < n; k++)
					owe(st, slot_data[h*BLOCK_BYTES + k], 1'b1, k + 1 == n);
			fill[h]  = 0;
			ended[h] = 1'b0;
			// popping the slot being written kills the rest of that chunk
			if (open_ok && open_idx == h) begin
				open_ok = 1'b0;
				if (in_chunk) begin
					dropped = 1'b1;
					left    = 0;
				end
			end
			head = (h + 1) % SLOTS;
		endfunction

		// first beat: coalesce into the open slot, claim a new tail slot, or drop the chunk
		function void open_chunk(int unsigned size);
			in_chunk = 1'b1;
			dropped  = 1'b0;
			left     = 0;
			if (size > BLOCK_BYTES) begin
				dropped = 1'b1;
				return;
			end
			if (!(open_ok && !ended[open_idx] && BLOCK_BYTES - fill[open_idx] >= size)) begin
				if ((tail + SLOTS - head) % SLOTS >= SLOTS - 1) begin
					dropped = 1'b1;
					return;
				end
				open_idx        = tail;
				open_ok         = 1'b1;
				fill[open_idx]  = 0;
				ended[open_idx] = 1'b0;
				tail            = (tail + 1) % SLOTS;
			end
			left = size;
		endfunction

		function void absorb_beat(req_beat_t b);
			if (b.req_type == REQ_READ) begin
				pop_head(b.read_capacity);
				return;
			end
			if (b.first_beat)
				open_chunk(b.chunk_size);
			if (!in_chunk) begin
				if (b.last_beat)
					owe(ST_REJECTED, 8'h00, 1'b0, 1'b1);
				return;
			end
			if (!dropped && open_ok && left > 0) begin
				if (fill[open_idx] < BLOCK_BYTES) begin
					slot_data[open_idx*BLOCK_BYTES + fill[open_idx]] = b.data_byte;
					fill[open_idx]++;
				end
				left--;
			end
			if (b.last_beat) begin
				if (!dropped && open_ok && b.end_mark)
					ended[open_idx] = 1'b1;
				owe(dropped ? ST_REJECTED : ST_OK, 8'h00, 1'b0, 1'b1);
				in_chunk = 1'b0;
				left     = 0;
			end
		endfunction

		function void compare_field(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				faults++;
				$display("%0t ns: %s mismatch, expected %0h, actual %0h",
					$time, field, want, got);
			end
		endfunction

		function void match_reply(rsp_beat_t got);
			rsp_beat_t want;
			if (owed.size() == 0) begin
				faults++;
				$display("%0t ns: reply beat with none outstanding, expected none, actual %h",
					$time, got);
				return;
			end
			want = owed.pop_front();
			compare_field("status", 8'(want.status), 8'(got.status));
			compare_field("out_byte", want.out_byte, got.out_byte);
			compare_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
			compare_field("last_result", 8'(want.last_result), 8'(got.last_result));
		endfunction

	endclass

endpackage

// File: bench/coalescing_message_ring_buffer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_message_ring_buffer_test
// drives write chunks and read requests into the message ring, mirrors every
// accepted beat in an untimed model and checks each reply beat in order;
// a directed opening covers the corner cases, then random chunk and read
// traffic runs under several sender and receiver idling patterns
// ----------------------------------------------------------------------------
module coalescing_message_ring_buffer_test;

	import cmrb_pkg::*;
	import ring_mirror_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_beat_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_beat_t rsp;

	// idling odds in percent, changed per phase
	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;
	// asks the receiver for one long hold-off
	bit          hold_ask  = 1'b0;

	ring_mirror  mirror = new();

	coalescing_message_ring_buffer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop in case the ring hangs
	initial begin
		#1000000;
		$display("Regression FAIL");
		$finish;
	end

	// both handshakes sampled at the edge, before any of this edge's updates land
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				mirror.match_reply(rsp);
			if (req_valid && req_ready)
				mirror.absorb_beat(req);
		end
	end

	// receiver: random stalls, plus one long hold-off counted here
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (hold_ask) begin
				hold_ask  = 1'b0;
				hold_left = 300;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// write beat; fields the block ignores carry random bits
	function automatic req_beat_t write_beat(int unsigned size, bit first, bit last,
			int unsigned data, bit endm);
		logic [31:0] r;
		req_beat_t   b;
		r            = $urandom;
		b            = r[$bits(req_beat_t)-1:0];
		b.req_type   = REQ_WRITE;
		b.chunk_size = CNT_W'(size);
		b.first_beat = first;
		b.last_beat  = last;
		b.data_byte  = 8'(data);
		b.end_mark   = endm;
		return b;
	endfunction

	function automatic req_beat_t read_req(int unsigned cap);
		logic [31:0] r;
		req_beat_t   b;
		r               = $urandom;
		b               = r[$bits(req_beat_t)-1:0];
		b.req_type      = REQ_READ;
		b.read_capacity = CNT_W'(cap);
		return b;
	endfunction

	// offer one beat and hold it until the ring takes it
	task automatic send(input req_beat_t b);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= b;
		do @(posedge clk); while (!req_ready);
	endtask

	// one chunk of beats; now and then a read slips in mid-chunk
	task automatic send_chunk(int unsigned size, int unsigned beats, bit endm);
		for (int i = 0; i < beats; i++) begin
			if (i > 0 && $urandom_range(99) < 4)
				send(read_req(127));
			send(write_beat(i == 0 ? size : $urandom_range(127), i == 0, i == beats - 1,
				$urandom_range(255), i == beats - 1 ? endm : bit'($urandom_range(1))));
		end
	endtask

	initial begin
		int unsigned sent;
		int unsigned pick;
		int unsigned size;
		int unsigned beats;
		int unsigned guard;
		logic [31:0] r;

		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed opening ----
		// read of an empty ring
		send(read_req(0));
		// stray middle beat is ignored, stray last beat is rejected
		send(write_beat(0, 1'b0, 1'b0, 8'hFF, 1'b1));
		send(write_beat(127, 1'b0, 1'b1, 8'h00, 1'b0));
		// zero-size chunk only closes a fresh slot; read it back with no capacity
		send(write_beat(0, 1'b1, 1'b1, 8'h00, 1'b1));
		send(read_req(0));
		// oversized chunks, one beat and two beats
		send(write_beat(65, 1'b1, 1'b1, 8'h00, 1'b1));
		send(write_beat(127, 1'b1, 1'b0, 8'hFF, 1'b1));
		send(write_beat(0, 1'b0, 1'b1, 8'h00, 1'b1));
		// two bytes, then one byte coalesced with an extra beat past its size
		send(write_beat(2, 1'b1, 1'b0, 8'h00, 1'b0));
		send(write_beat(0, 1'b0, 1'b1, 8'hFF, 1'b0));
		send(write_beat(1, 1'b1, 1'b0, 8'hA5, 1'b0));
		send(write_beat(0, 1'b0, 1'b1, 8'h3C, 1'b0));
		// reader too small, then a full pop
		send(read_req(2));
		send(read_req(127));
		// short chunk: size 64 but ended after two bytes
		send(write_beat(64, 1'b1, 1'b0, 8'h5A, 1'b1));
		send(write_beat(0, 1'b0, 1'b1, 8'hC3, 1'b1));
		// fill the ring, then one chunk too many
		send(write_beat(0, 1'b1, 1'b1, 8'h00, 1'b1));
		send(write_beat(0, 1'b1, 1'b1, 8'h00, 1'b1));
		send(write_beat(1, 1'b1, 1'b1, 8'h77, 1'b0));
		repeat (3) send(read_req(127));
		// read pops the slot under write; rest of the chunk is dropped
		send(write_beat(4, 1'b1, 1'b0, 8'h12, 1'b0));
		send(read_req(127));
		send(write_beat(0, 1'b0, 1'b0, 8'h34, 1'b0));
		send(write_beat(0, 1'b0, 1'b1, 8'h56, 1'b1));

		// ---- random traffic in four idling phases ----
		for (int phase = 0; phase < 4; phase++) begin
			sent = 0;
			case (phase)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
					// receiver holds off while a full-size message goes in and out
					hold_ask  = 1'b1;
					send_chunk(BLOCK_BYTES, BLOCK_BYTES, 1'b1);
					send(read_req(127));
				end
				1: begin
					idle_pct  = 82;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 82;
				end
				default: begin
					idle_pct  = 27;
					stall_pct = 27;
				end
			endcase
			while (sent < 14) begin
				pick = $urandom_range(99);
				if (pick < 55) begin
					// mostly short chunks, a few long ones, a few oversized
					pick = $urandom_range(99);
					if (pick < 80)
						size = $urandom_range(8);
					else if (pick < 90)
						size = $urandom_range(9, 16);
					else if (pick < 95)
						size = $urandom_range(48, BLOCK_BYTES);
					else
						size = $urandom_range(BLOCK_BYTES + 1, 127);
					if (size > BLOCK_BYTES)
						beats = $urandom_range(1, 3);
					else if ($urandom_range(99) < 20)
						beats = $urandom_range(1, size + 3);
					else
						beats = (size == 0) ? 1 : size;
					send_chunk(size, beats, bit'($urandom_range(1)));
					sent += beats;
				end else if (pick < 90) begin
					send(read_req($urandom_range(99) < 70 ? 127 : $urandom_range(127)));
					sent++;
				end else begin
					// noise: any bits at all
					r = $urandom;
					send(r[$bits(req_beat_t)-1:0]);
					sent++;
				end
			end
		end
		req_valid <= 1'b0;

		// drain, then watch a while for stray replies
		guard = 0;
		while (mirror.owed.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (100) @(posedge clk);
		if (mirror.owed.size() != 0) begin
			mirror.faults++;
			$display("%0t ns: %0d reply beats never arrived, first expected %h",
				$time, mirror.owed.size(), mirror.owed[0]);
		end
		if (mirror.faults == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
